// File: src/line_buffered_3x3_gradient_filter_macros.svh
// Assertion helpers shared by the filter modules.
`ifndef LINE_BUFFERED_3X3_GRADIENT_FILTER_MACROS_SVH
`define LINE_BUFFERED_3X3_GRADIENT_FILTER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LB3G_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define LB3G_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/lb3g_pkg.sv
package lb3g_pkg;

  // Image geometry limits.
  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_HEIGHT   = 4096;
  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  // Field and counter widths.
  localparam int PIX_W        = 8;
  localparam int FILT_W       = 11;
  localparam int CFG_WIDTH_W  = 11;
  localparam int CFG_HEIGHT_W = 13;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int WID_W        = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W        = (WID_W > CFG_WIDTH_W) ? WID_W : CFG_WIDTH_W;
  localparam int ROW_W        = $clog2(MAX_HEIGHT);
  localparam int HGT_W        = $clog2(MAX_HEIGHT + 1);
  localparam int SEEN_W       = $clog2(MAX_WIDTH + 2);

  // Register port.
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // Queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_index_t;

  // Effective (clamped) frame size.
  typedef struct packed {
    logic [WID_W-1:0] width;
    logic [HGT_W-1:0] height;
  } frame_size_t;

  // One classified item as the back end consumes it.
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [COL_W-1:0] column;
    logic             emit;
    logic [2:0]       row_ok;
    logic [2:0]       col_ok;
    logic             last;
  } work_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// File: src/lb3g_regs.sv
module lb3g_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lb3g_pkg::ADDR_W-1:0] paddr,
  input  logic [lb3g_pkg::DATA_W-1:0] pwdata,
  output logic [lb3g_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output lb3g_pkg::frame_size_t      size
);

  logic [lb3g_pkg::CFG_WIDTH_W-1:0]  width_r;
  logic [lb3g_pkg::CFG_HEIGHT_W-1:0] height_r;
  lb3g_pkg::reg_index_t              idx;
  logic                              wr_en;

  assign pready = 1'b1;
  assign idx    = lb3g_pkg::reg_index_t'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;

  // Register writes on the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= lb3g_pkg::CFG_WIDTH_W'(lb3g_pkg::RESET_WIDTH);
      height_r <= lb3g_pkg::CFG_HEIGHT_W'(lb3g_pkg::RESET_HEIGHT);
    end else if (wr_en) begin
      unique case (idx)
        lb3g_pkg::REG_IMAGE_WIDTH:  width_r  <= pwdata[lb3g_pkg::CFG_WIDTH_W-1:0];
        lb3g_pkg::REG_IMAGE_HEIGHT: height_r <= pwdata[lb3g_pkg::CFG_HEIGHT_W-1:0];
      endcase
    end
  end

  // Read back the stored values.
  always_comb begin
    unique case (idx)
      lb3g_pkg::REG_IMAGE_WIDTH:  prdata = lb3g_pkg::DATA_W'(width_r);
      lb3g_pkg::REG_IMAGE_HEIGHT: prdata = lb3g_pkg::DATA_W'(height_r);
    endcase
  end

  // Clamp the sizes: zero acts as one, oversize acts as the maximum.
  always_comb begin
    if (width_r == '0) begin
      size.width = lb3g_pkg::WID_W'(1);
    end else if (lb3g_pkg::CMP_W'(width_r) > lb3g_pkg::CMP_W'(lb3g_pkg::MAX_WIDTH)) begin
      size.width = lb3g_pkg::WID_W'(lb3g_pkg::MAX_WIDTH);
    end else begin
      size.width = lb3g_pkg::WID_W'(width_r);
    end
    if (height_r == '0) begin
      size.height = lb3g_pkg::HGT_W'(1);
    end else if (lb3g_pkg::HGT_W'(height_r) > lb3g_pkg::HGT_W'(lb3g_pkg::MAX_HEIGHT)) begin
      size.height = lb3g_pkg::HGT_W'(lb3g_pkg::MAX_HEIGHT);
    end else begin
      size.height = lb3g_pkg::HGT_W'(height_r);
    end
  end

endmodule

// File: src/lb3g_front.sv
`include "line_buffered_3x3_gradient_filter_macros.svh"

module lb3g_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lb3g_pkg::frame_size_t      size,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [lb3g_pkg::PIX_W-1:0] in_pixel,
  input  logic                       in_is_pixel,
  input  lb3g_pkg::queue_status_t    q_status,
  output logic                       push_valid,
  output lb3g_pkg::work_item_t       push_item
);

  logic [lb3g_pkg::COL_W-1:0]  in_col_r, in_col_nxt, in_col_eff;
  logic [lb3g_pkg::COL_W-1:0]  out_col_r, out_col_nxt, out_col_eff;
  logic [lb3g_pkg::ROW_W-1:0]  out_row_r, out_row_nxt;
  logic [lb3g_pkg::SEEN_W-1:0] seen_r, seen_nxt;
  logic [lb3g_pkg::WID_W-1:0]  in_col_inc, out_col_inc;
  logic [lb3g_pkg::HGT_W-1:0]  row_ext, row_inc;
  logic                        in_col_wrap, out_col_wrap, row_end;
  logic                        warm, emit, last_c, accept;

  assign in_ready   = !q_status.full;
  assign push_valid = in_valid;
  assign accept     = in_valid && in_ready;

  // Position bookkeeping for the incoming item and the next result.
  always_comb begin
    in_col_eff  = (lb3g_pkg::WID_W'(in_col_r) >= size.width) ? '0 : in_col_r;
    out_col_eff = (lb3g_pkg::WID_W'(out_col_r) >= size.width) ? '0 : out_col_r;
    in_col_inc  = lb3g_pkg::WID_W'(in_col_eff) + 1'b1;
    out_col_inc = lb3g_pkg::WID_W'(out_col_eff) + 1'b1;
    in_col_wrap  = in_col_inc >= size.width;
    out_col_wrap = out_col_inc >= size.width;
    row_ext = lb3g_pkg::HGT_W'(out_row_r);
    row_inc = row_ext + 1'b1;
    row_end = row_inc >= size.height;
    warm    = seen_r < (lb3g_pkg::SEEN_W'(size.width) + 1'b1);
    emit    = !warm;
    last_c  = emit && out_col_wrap && row_end;
  end

  // Classified item for the back end.
  always_comb begin
    push_item.pixel     = in_is_pixel ? in_pixel : '0;
    push_item.column    = in_col_eff;
    push_item.emit      = emit;
    push_item.row_ok[0] = (out_row_r != '0) && (row_ext <= size.height);
    push_item.row_ok[1] = row_ext < size.height;
    push_item.row_ok[2] = row_inc < size.height;
    push_item.col_ok[0] = out_col_eff != '0;
    push_item.col_ok[1] = 1'b1;
    push_item.col_ok[2] = !out_col_wrap;
    push_item.last      = last_c;
  end

  // Next counter values; the frame's last result restarts everything.
  always_comb begin
    if (last_c || in_col_wrap) begin
      in_col_nxt = '0;
    end else begin
      in_col_nxt = lb3g_pkg::COL_W'(in_col_inc);
    end
    if (warm) begin
      seen_nxt = seen_r + 1'b1;
    end else if (last_c) begin
      seen_nxt = '0;
    end else begin
      seen_nxt = seen_r;
    end
    if (emit && out_col_wrap) begin
      out_col_nxt = '0;
    end else if (emit) begin
      out_col_nxt = lb3g_pkg::COL_W'(out_col_inc);
    end else begin
      out_col_nxt = out_col_eff;
    end
    if (emit && out_col_wrap) begin
      out_row_nxt = row_end ? '0 : lb3g_pkg::ROW_W'(row_inc);
    end else begin
      out_row_nxt = out_row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      seen_r    <= '0;
    end else if (accept) begin
      in_col_r  <= in_col_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      seen_r    <= seen_nxt;
    end
  end

  // A frame end returns the counters to the frame start.
  `LB3G_ASSERT_NEXT(a_frame_restart, clk, rst_n, accept && last_c, (in_col_r == '0) && (seen_r == '0) && (out_row_r == '0), "counters not cleared after frame end")
  // No result is classified during warm-up.
  `LB3G_ASSERT_NOW(a_warm_no_emit, clk, rst_n, warm, !push_item.emit && !push_item.last, "result marked during warm-up")

endmodule

// File: src/lb3g_queue.sv
`include "line_buffered_3x3_gradient_filter_macros.svh"

module lb3g_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push_valid,
  input  lb3g_pkg::work_item_t    push_item,
  input  logic                    pop,
  output lb3g_pkg::work_item_t    head,
  output lb3g_pkg::queue_status_t q_status
);

  lb3g_pkg::work_item_t              q_mem_r [lb3g_pkg::QUEUE_DEPTH];
  logic [lb3g_pkg::QPTR_W-1:0]       wr_ptr_r, rd_ptr_r;
  logic [lb3g_pkg::QCNT_W-1:0]       count_r;
  logic                              push, pop_fire;

  assign q_status.full  = count_r == lb3g_pkg::QCNT_W'(lb3g_pkg::QUEUE_DEPTH);
  assign q_status.empty = count_r == '0;
  assign push     = push_valid && !q_status.full;
  assign pop_fire = pop && !q_status.empty;
  assign head     = q_mem_r[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == lb3g_pkg::QPTR_W'(lb3g_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : wr_ptr_r + 1'b1;
      end
      if (pop_fire) begin
        rd_ptr_r <= (rd_ptr_r == lb3g_pkg::QPTR_W'(lb3g_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop_fire) begin
        count_r <= count_r + 1'b1;
      end else if (pop_fire && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  `LB3G_ASSERT_NEXT(a_q_grow, clk, rst_n, push && !pop_fire, count_r == $past(count_r) + 1'b1, "queue count did not grow")
  `LB3G_ASSERT_NEXT(a_q_shrink, clk, rst_n, pop_fire && !push, count_r == $past(count_r) - 1'b1, "queue count did not shrink")

endmodule

// File: src/lb3g_back.sv
`include "line_buffered_3x3_gradient_filter_macros.svh"

module lb3g_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lb3g_pkg::queue_status_t     q_status,
  input  lb3g_pkg::work_item_t        head,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [lb3g_pkg::FILT_W-1:0] out_filtered,
  output logic                        out_frame_last
);

  // Line memories: the row two back and the row one back, by column.
  logic [lb3g_pkg::PIX_W-1:0] top_mem [lb3g_pkg::MAX_WIDTH];
  logic [lb3g_pkg::PIX_W-1:0] mid_mem [lb3g_pkg::MAX_WIDTH];

  logic [lb3g_pkg::PIX_W-1:0] top_rd_r, mid_rd_r, fwd_top_r, fwd_mid_r;
  logic [lb3g_pkg::PIX_W-1:0] top_eff, mid_eff;
  logic                       fwd_r;
  logic                       b2_valid_r;
  lb3g_pkg::work_item_t       b2_item_r;
  logic [lb3g_pkg::PIX_W-1:0] win_r   [3][3];
  logic [lb3g_pkg::PIX_W-1:0] win_nxt [3][3];
  logic [lb3g_pkg::PIX_W-1:0] t00, t01, t10, t12, t21, t22;
  logic [lb3g_pkg::FILT_W:0]  pos_sum, neg_sum, acc;
  logic                       out_valid_r, out_last_r;
  logic [lb3g_pkg::FILT_W-1:0] out_filt_r;
  logic                       advance, wr_en;

  assign advance = !out_valid_r || out_ready;
  assign pop     = advance && !q_status.empty;
  assign wr_en   = advance && b2_valid_r;

  // Line memory read, issued as an item leaves the queue.
  always_ff @(posedge clk) begin
    if (pop) begin
      top_rd_r <= top_mem[head.column];
      mid_rd_r <= mid_mem[head.column];
    end
  end

  // Line memory write: both rows move up by one at this column.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      top_mem[b2_item_r.column] <= mid_eff;
      mid_mem[b2_item_r.column] <= b2_item_r.pixel;
    end
  end

  // A read that meets the write of the previous item at the same column
  // takes the written values instead of the memory's old contents.
  assign top_eff = fwd_r ? fwd_top_r : top_rd_r;
  assign mid_eff = fwd_r ? fwd_mid_r : mid_rd_r;

  always_ff @(posedge clk) begin
    if (pop) begin
      b2_item_r <= head;
      fwd_r     <= b2_valid_r && (b2_item_r.column == head.column);
      fwd_top_r <= mid_eff;
      fwd_mid_r <= b2_item_r.pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b2_valid_r <= 1'b0;
    end else if (advance) begin
      b2_valid_r <= pop;
    end
  end

  // Window shifts left and takes the new column on the right.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 2; j++) begin
        win_nxt[i][j] = win_r[i][j+1];
      end
    end
    win_nxt[0][2] = top_eff;
    win_nxt[1][2] = mid_eff;
    win_nxt[2][2] = b2_item_r.pixel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[i][j] <= '0;
        end
      end
    end else if (wr_en) begin
      win_r <= win_nxt;
    end
  end

  // Weighted sum: weight is row plus column offset; edges are masked.
  always_comb begin
    t00 = (b2_item_r.row_ok[0] && b2_item_r.col_ok[0]) ? win_nxt[0][0] : '0;
    t01 = (b2_item_r.row_ok[0] && b2_item_r.col_ok[1]) ? win_nxt[0][1] : '0;
    t10 = (b2_item_r.row_ok[1] && b2_item_r.col_ok[0]) ? win_nxt[1][0] : '0;
    t12 = (b2_item_r.row_ok[1] && b2_item_r.col_ok[2]) ? win_nxt[1][2] : '0;
    t21 = (b2_item_r.row_ok[2] && b2_item_r.col_ok[1]) ? win_nxt[2][1] : '0;
    t22 = (b2_item_r.row_ok[2] && b2_item_r.col_ok[2]) ? win_nxt[2][2] : '0;
    pos_sum = (lb3g_pkg::FILT_W+1)'(t12) + (lb3g_pkg::FILT_W+1)'(t21) +
              ((lb3g_pkg::FILT_W+1)'(t22) << 1);
    neg_sum = (lb3g_pkg::FILT_W+1)'(t01) + (lb3g_pkg::FILT_W+1)'(t10) +
              ((lb3g_pkg::FILT_W+1)'(t00) << 1);
    acc     = pos_sum - neg_sum;
  end

  // Output register; it frees as the result is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= b2_valid_r && b2_item_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && b2_item_r.emit) begin
      out_filt_r <= acc[lb3g_pkg::FILT_W-1:0];
      out_last_r <= b2_item_r.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_filtered   = out_filt_r;
  assign out_frame_last = out_last_r;

  // A stalled back end keeps its in-flight item.
  `LB3G_ASSERT_NEXT(a_b2_hold, clk, rst_n, b2_valid_r && !advance, b2_valid_r && $stable(b2_item_r), "stalled item lost")
  // A new result only comes from an item that produces one.
  `LB3G_ASSERT_NEXT(a_out_src, clk, rst_n, advance && !(b2_valid_r && b2_item_r.emit), !out_valid_r, "result without source item")

endmodule

// File: src/line_buffered_3x3_gradient_filter.sv
// Channel   Handshake              Payload
// input     in_valid / in_ready    in_pixel[7:0], in_is_pixel
// result    out_valid / out_ready  out_filtered[10:0] (signed), out_frame_last
// config    psel/penable/pwrite    paddr[2:0], pwdata, prdata, pready
//
// One item per clock sustained unless a stall on out_ready holds the back end; an item
// passes through the queue entry, the line memory read and the output register.
// The line memories have one read and one write port each; the read data register
// is bypassed when consecutive items share a column.
// Reset is synchronous, active low; no clearing pass, the line memories start unknown.
// A stall on out_ready holds the back end; the four-entry queue keeps in_ready high
// until it fills.
module line_buffered_3x3_gradient_filter (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [lb3g_pkg::PIX_W-1:0]  in_pixel,
  input  logic                        in_is_pixel,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [lb3g_pkg::FILT_W-1:0] out_filtered,
  output logic                        out_frame_last,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lb3g_pkg::ADDR_W-1:0] paddr,
  input  logic [lb3g_pkg::DATA_W-1:0] pwdata,
  output logic [lb3g_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  lb3g_pkg::frame_size_t   size;
  lb3g_pkg::queue_status_t q_status;
  lb3g_pkg::work_item_t    push_item, head;
  logic                    push_valid, pop;

  // Size registers.
  lb3g_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .size    (size)
  );

  // Position tracking and classification.
  lb3g_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .size        (size),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_pixel    (in_pixel),
    .in_is_pixel (in_is_pixel),
    .q_status    (q_status),
    .push_valid  (push_valid),
    .push_item   (push_item)
  );

  // Decoupling queue.
  lb3g_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .pop        (pop),
    .head       (head),
    .q_status   (q_status)
  );

  // Line memories, window and weighted sum.
  lb3g_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_status       (q_status),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_filtered   (out_filtered),
    .out_frame_last (out_frame_last)
  );

endmodule
